[rtl/aanf_pkg.sv]
// shared widths, fixed-point constants, stage payload types and rounding helper
package aanf_pkg;

  // sample and coefficient geometry
  localparam int NUM_PTS    = 8;
  localparam int IN_W       = 15;
  localparam int OUT_W      = 19;
  localparam int IN_DATA_W  = NUM_PTS * IN_W;
  localparam int OUT_DATA_W = NUM_PTS * OUT_W;

  // internal widths: first butterfly, second butterfly, multiplier operand
  localparam int S_W = IN_W + 1;
  localparam int E_W = IN_W + 2;
  localparam int M_W = IN_W + 3;

  // pipeline register stages from input to output
  localparam int NUM_STG = 4;

  // fixed-point multiplier constants
  localparam int FRAC_BITS = 14;
  localparam int K_W       = FRAC_BITS + 2;
  localparam int PROD_W    = M_W + K_W;

  localparam longint Q30_C4   = 64'sd759250125;
  localparam longint Q30_C6   = 64'sd410903207;
  localparam longint Q30_C2M6 = 64'sd581104888;
  localparam longint Q30_C2P6 = 64'sd1402911301;

  localparam longint RND30 = 64'sd1 <<< (29 - FRAC_BITS);

  localparam logic signed [K_W-1:0] K_C4   = K_W'((Q30_C4   + RND30) >>> (30 - FRAC_BITS));
  localparam logic signed [K_W-1:0] K_C6   = K_W'((Q30_C6   + RND30) >>> (30 - FRAC_BITS));
  localparam logic signed [K_W-1:0] K_C2M6 = K_W'((Q30_C2M6 + RND30) >>> (30 - FRAC_BITS));
  localparam logic signed [K_W-1:0] K_C2P6 = K_W'((Q30_C2P6 + RND30) >>> (30 - FRAC_BITS));

  localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(64'sd1 <<< (FRAC_BITS - 1));

  // after butterflies
  typedef struct packed {
    logic signed [M_W-1:0] c0;
    logic signed [M_W-1:0] c4;
    logic signed [M_W-1:0] m4;
    logic signed [M_W-1:0] od;
    logic signed [E_W-1:0] e3;
    logic signed [E_W-1:0] o0;
    logic signed [E_W-1:0] o1;
    logic signed [E_W-1:0] o2;
    logic signed [S_W-1:0] t07;
  } stg1_t;

  // raw products plus pass-through terms
  typedef struct packed {
    logic signed [PROD_W-1:0] p_r;
    logic signed [PROD_W-1:0] p_w;
    logic signed [PROD_W-1:0] p_a;
    logic signed [PROD_W-1:0] p_b;
    logic signed [PROD_W-1:0] p_h;
    logic signed [M_W-1:0]    c0;
    logic signed [M_W-1:0]    c4;
    logic signed [E_W-1:0]    e3;
    logic signed [S_W-1:0]    t07;
  } stg2_t;

  // rounded and recombined terms
  typedef struct packed {
    logic signed [M_W-1:0]   c0;
    logic signed [M_W-1:0]   c4;
    logic signed [OUT_W-1:0] c2;
    logic signed [OUT_W-1:0] c6;
    logic signed [OUT_W-1:0] a;
    logic signed [OUT_W-1:0] b;
    logic signed [OUT_W-1:0] p;
    logic signed [OUT_W-1:0] q;
  } stg3_t;

  // round half up then floor shift, keeping the output width
  function automatic logic signed [OUT_W-1:0] rnd(input logic signed [PROD_W-1:0] prod);
    logic signed [PROD_W-1:0] tmp;
    tmp = prod + PROD_HALF;
    return tmp[FRAC_BITS +: OUT_W];
  endfunction

endpackage

[rtl/aan_fdct_8_point.sv]
// top level: 8-point aan forward dct, four-stage pipeline with stream handshake
//
// Takes one vector of eight 15-bit signed samples per beat and returns the
// eight unscaled AAN coefficients (19-bit signed, natural order, per-coefficient
// scale left to the quantizer) as one output beat per vector. Throughput is one
// vector per clock while the output is not stalled; each vector passes in order
// through the four register stages: butterflies, constant multipliers (Q14),
// rounding with partial recombination, and final odd butterflies. Each stage
// holds its data under back pressure, so a stalled output fills the pipeline
// up to four vectors before in_tready drops; any empty stage keeps it high.
module aan_fdct_8_point (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // sample_0 .. sample_7, 15 bits each from bit 0 up
  input  logic [aanf_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // coef_0 .. coef_7, 19 bits each from bit 0 up
  output logic [aanf_pkg::OUT_DATA_W-1:0] out_tdata
);
  import aanf_pkg::*;

  logic [NUM_STG-1:0] vld_r, vld_nxt;
  logic [NUM_STG-1:0] rdy, vin, en;
  stg1_t              st1;
  stg2_t              st2;
  stg3_t              st3;

  // ready ripples back: a stage loads when empty or when its successor moves
  always_comb begin
    rdy[NUM_STG-1] = !vld_r[NUM_STG-1] || out_tready;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vin[0] = in_tvalid;
    for (int k = 1; k < NUM_STG; k++) begin
      vin[k] = vld_r[k-1];
    end
    for (int k = 0; k < NUM_STG; k++) begin
      en[k]      = rdy[k] && vin[k];
      vld_nxt[k] = rdy[k] ? vin[k] : vld_r[k];
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  aanf_butterfly u_bfly (
    .clk  (clk),
    .en   (en[0]),
    .data (in_tdata),
    .st_r (st1)
  );

  aanf_mult u_mult (
    .clk  (clk),
    .en   (en[1]),
    .st   (st1),
    .st_r (st2)
  );

  aanf_round u_round (
    .clk  (clk),
    .en   (en[2]),
    .st   (st2),
    .st_r (st3)
  );

  aanf_combine u_comb (
    .clk    (clk),
    .en     (en[3]),
    .st     (st3),
    .data_r (out_tdata)
  );

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[NUM_STG-1];

  // any empty stage must leave room for a new beat
  a_room_when_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(&vld_r) |-> in_tready)
    else $error("in_tready low with an empty pipeline stage");

  // a taken output frees the whole chain
  a_ready_passes_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("in_tready low while output is taken");

  // occupancy changes only by accepted input and output beats
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      ($countones(vld_r) + $past(int'(out_tvalid && out_tready)) ==
       $past($countones(vld_r)) + $past(int'(in_tvalid && in_tready))))
    else $error("pipeline occupancy out of step with handshakes");

endmodule

[rtl/aanf_butterfly.sv]
// stage one: input butterflies, even half sums and odd half partial sums
module aanf_butterfly (
  input  logic                           clk,
  input  logic                           en,
  input  logic [aanf_pkg::IN_DATA_W-1:0] data,
  output aanf_pkg::stg1_t                st_r
);
  import aanf_pkg::*;

  logic signed [IN_W-1:0] d [NUM_PTS];
  logic signed [S_W-1:0]  s07, t07, s16, t16, s25, t25, s34, t34;
  logic signed [E_W-1:0]  e0, e1, e2, e3, o0, o1, o2;
  stg1_t                  st_nxt;

  // unpack samples
  always_comb begin
    for (int i = 0; i < NUM_PTS; i++) begin
      d[i] = $signed(data[i*IN_W +: IN_W]);
    end
  end

  // two butterfly levels plus the c0 and c4 terms and the multiplier operands
  always_comb begin
    s07 = S_W'(d[0]) + S_W'(d[7]);
    t07 = S_W'(d[0]) - S_W'(d[7]);
    s16 = S_W'(d[1]) + S_W'(d[6]);
    t16 = S_W'(d[1]) - S_W'(d[6]);
    s25 = S_W'(d[2]) + S_W'(d[5]);
    t25 = S_W'(d[2]) - S_W'(d[5]);
    s34 = S_W'(d[3]) + S_W'(d[4]);
    t34 = S_W'(d[3]) - S_W'(d[4]);

    e0 = E_W'(s07) + E_W'(s34);
    e3 = E_W'(s07) - E_W'(s34);
    e1 = E_W'(s16) + E_W'(s25);
    e2 = E_W'(s16) - E_W'(s25);
    o0 = E_W'(t34) + E_W'(t25);
    o1 = E_W'(t25) + E_W'(t16);
    o2 = E_W'(t16) + E_W'(t07);

    st_nxt.c0  = M_W'(e0) + M_W'(e1);
    st_nxt.c4  = M_W'(e0) - M_W'(e1);
    st_nxt.m4  = M_W'(e2) + M_W'(e3);
    st_nxt.od  = M_W'(o0) - M_W'(o2);
    st_nxt.e3  = e3;
    st_nxt.o0  = o0;
    st_nxt.o1  = o1;
    st_nxt.o2  = o2;
    st_nxt.t07 = t07;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

endmodule

[rtl/aanf_mult.sv]
// stage two: five constant multiplications, full-width products registered
module aanf_mult (
  input  logic            clk,
  input  logic            en,
  input  aanf_pkg::stg1_t st,
  output aanf_pkg::stg2_t st_r
);
  import aanf_pkg::*;

  stg2_t st_nxt;

  // one multiplier per rotation term
  always_comb begin
    st_nxt.p_r = PROD_W'(st.m4) * PROD_W'(K_C4);
    st_nxt.p_w = PROD_W'(st.od) * PROD_W'(K_C6);
    st_nxt.p_a = PROD_W'(st.o0) * PROD_W'(K_C2M6);
    st_nxt.p_b = PROD_W'(st.o2) * PROD_W'(K_C2P6);
    st_nxt.p_h = PROD_W'(st.o1) * PROD_W'(K_C4);
    st_nxt.c0  = st.c0;
    st_nxt.c4  = st.c4;
    st_nxt.e3  = st.e3;
    st_nxt.t07 = st.t07;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

endmodule

[rtl/aanf_round.sv]
// stage three: product rounding and first recombination of both halves
module aanf_round (
  input  logic            clk,
  input  logic            en,
  input  aanf_pkg::stg2_t st,
  output aanf_pkg::stg3_t st_r
);
  import aanf_pkg::*;

  logic signed [OUT_W-1:0] r, w, ma, mb, h, e3x, t07x;
  stg3_t                   st_nxt;

  // round products, then even outputs and odd partials
  always_comb begin
    r    = rnd(st.p_r);
    w    = rnd(st.p_w);
    ma   = rnd(st.p_a);
    mb   = rnd(st.p_b);
    h    = rnd(st.p_h);
    e3x  = OUT_W'(st.e3);
    t07x = OUT_W'(st.t07);

    st_nxt.c0 = st.c0;
    st_nxt.c4 = st.c4;
    st_nxt.c2 = e3x + r;
    st_nxt.c6 = e3x - r;
    st_nxt.a  = ma + w;
    st_nxt.b  = mb + w;
    st_nxt.p  = t07x + h;
    st_nxt.q  = t07x - h;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

endmodule

[rtl/aanf_combine.sv]
// stage four: final odd butterflies and output packing
module aanf_combine (
  input  logic                            clk,
  input  logic                            en,
  input  aanf_pkg::stg3_t                 st,
  output logic [aanf_pkg::OUT_DATA_W-1:0] data_r
);
  import aanf_pkg::*;

  logic signed [OUT_W-1:0]      c [NUM_PTS];
  logic [OUT_DATA_W-1:0]        data_nxt;

  // odd outputs, results fit the output width so wrap is exact
  always_comb begin
    c[0] = OUT_W'(st.c0);
    c[4] = OUT_W'(st.c4);
    c[2] = st.c2;
    c[6] = st.c6;
    c[5] = st.q + st.a;
    c[3] = st.q - st.a;
    c[1] = st.p + st.b;
    c[7] = st.p - st.b;
    for (int i = 0; i < NUM_PTS; i++) begin
      data_nxt[i*OUT_W +: OUT_W] = c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

[sim/tb_top.sv]
// testbench for the 8-point aan forward dct: corner and random vectors against a scoreboard
module tb_top;
  import aanf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int NUM_RANDOM  = 500;

  typedef logic [IN_DATA_W-1:0]    vec_in_t;
  typedef logic [OUT_DATA_W-1:0]   vec_out_t;
  typedef logic signed [IN_W-1:0]  sample_t;
  typedef logic signed [OUT_W-1:0] coef_t;

  // multiplier constants rounded from 30 fraction bits down to FRAC_BITS
  localparam longint Q30_HALF = 64'sd1 <<< (29 - FRAC_BITS);
  localparam longint MUL_C4   = (Q30_C4   + Q30_HALF) >>> (30 - FRAC_BITS);
  localparam longint MUL_C6   = (Q30_C6   + Q30_HALF) >>> (30 - FRAC_BITS);
  localparam longint MUL_C2M6 = (Q30_C2M6 + Q30_HALF) >>> (30 - FRAC_BITS);
  localparam longint MUL_C2P6 = (Q30_C2P6 + Q30_HALF) >>> (30 - FRAC_BITS);

  // sign of each cosine basis over positions 0..7, bit n set for a positive weight
  localparam logic [63:0] BASIS_SIGNS = {8'h55, 8'hA5, 8'h4D, 8'h99,
                                         8'h71, 8'hC3, 8'h0F, 8'hFF};

  localparam sample_t SAMPLE_MAX = 15'sh3FFF;
  localparam sample_t SAMPLE_MIN = 15'sh4000;

  // product with a fixed-point constant, half added then floor shift
  function automatic longint mul_round(longint x, longint k);
    return (x * k + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  // eight unscaled aan coefficients of one sample vector
  function automatic vec_out_t aan_row_coefs(vec_in_t d);
    longint  x [8];
    longint  c [8];
    longint  s07, t07, s16, t16, s25, t25, s34, t34;
    longint  e0, e1, e2, e3, r;
    longint  o0, o1, o2, w, a, b, h, p, q;
    sample_t v;
    vec_out_t res;
    int      n;
    for (n = 0; n < 8; n++) begin
      v = d[n*IN_W +: IN_W];
      x[n] = v;
    end
    s07 = x[0] + x[7]; t07 = x[0] - x[7];
    s16 = x[1] + x[6]; t16 = x[1] - x[6];
    s25 = x[2] + x[5]; t25 = x[2] - x[5];
    s34 = x[3] + x[4]; t34 = x[3] - x[4];
    // even half
    e0 = s07 + s34; e3 = s07 - s34;
    e1 = s16 + s25; e2 = s16 - s25;
    r  = mul_round(e2 + e3, MUL_C4);
    c[0] = e0 + e1;
    c[4] = e0 - e1;
    c[2] = e3 + r;
    c[6] = e3 - r;
    // odd half
    o0 = t34 + t25;
    o1 = t25 + t16;
    o2 = t16 + t07;
    w  = mul_round(o0 - o2, MUL_C6);
    a  = mul_round(o0, MUL_C2M6) + w;
    b  = mul_round(o2, MUL_C2P6) + w;
    h  = mul_round(o1, MUL_C4);
    p  = t07 + h;
    q  = t07 - h;
    c[5] = q + a;
    c[3] = q - a;
    c[1] = p + b;
    c[7] = p - b;
    for (n = 0; n < 8; n++) res[n*OUT_W +: OUT_W] = OUT_W'(c[n]);
    return res;
  endfunction

  // expected coefficient vectors in input order
  class fdct_scoreboard;
    vec_out_t pending_coefs[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    function void note_samples(vec_in_t d);
      pending_coefs.push_back(aan_row_coefs(d));
    endfunction

    function void check_coefs(vec_out_t got);
      vec_out_t want;
      coef_t    wc, gc;
      int       k;
      if (pending_coefs.size() == 0) begin
        $error("coefficient beat with no vector outstanding: %h", got);
        errors++;
        return;
      end
      want = pending_coefs.pop_front();
      for (k = 0; k < 8; k++) begin
        wc = want[k*OUT_W +: OUT_W];
        gc = got[k*OUT_W +: OUT_W];
        if (wc !== gc) begin
          $error("coef_%0d: expected %0d, got %0d", k, wc, gc);
          errors++;
        end
      end
    endfunction
  endclass

  logic     clk        = 1'b0;
  logic     rst_n      = 1'b0;
  logic     in_tvalid  = 1'b0;
  logic     in_tready;
  vec_in_t  in_tdata   = '0;
  logic     out_tvalid;
  logic     out_tready = 1'b0;
  vec_out_t out_tdata;

  int tx_idle_pct = 35;
  int rx_idle_pct = 35;
  bit hold_req    = 1'b0;
  int cycle_cnt   = 0;

  fdct_scoreboard sb = new();

  aan_fdct_8_point dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock, period 4
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // beat monitor on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_samples(in_tdata);
      if (out_tvalid && out_tready) sb.check_coefs(out_tdata);
    end
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // offer one sample vector, with random gaps, until it is taken
  task automatic send_vec(input vec_in_t d);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    vec_in_t     d;
    logic [7:0]  mask;
    int          i, n, pol, kind;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // full-scale inputs matched to each basis sign, both polarities
    for (i = 0; i < 8; i++) begin
      mask = BASIS_SIGNS[i*8 +: 8];
      for (pol = 0; pol < 2; pol++) begin
        for (n = 0; n < 8; n++)
          d[n*IN_W +: IN_W] = (mask[n] ^ pol[0]) ? SAMPLE_MAX : SAMPLE_MIN;
        send_vec(d);
      end
    end

    // zero, all minus one, lone extremes, alternating bit patterns
    send_vec('0);
    send_vec({8{15'h7FFF}});
    d = '0;
    d[0 +: IN_W] = SAMPLE_MAX;
    send_vec(d);
    d = '0;
    d[7*IN_W +: IN_W] = SAMPLE_MIN;
    send_vec(d);
    send_vec({8{15'h2AAA}});
    send_vec({8{15'h5555}});

    // random vectors, with a no-gap stretch and a long result-side hold-off
    for (i = 0; i < NUM_RANDOM; i++) begin
      if (i == 150) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (i == 250) begin
        tx_idle_pct = 35;
        rx_idle_pct = 35;
      end else if (i == 300) begin
        hold_req    = 1'b1;
        tx_idle_pct = 0;
      end else if (i == 360) begin
        tx_idle_pct = 35;
      end
      kind = $urandom_range(9);
      for (n = 0; n < 8; n++) begin
        if (kind <= 5) begin
          d[n*IN_W +: IN_W] = IN_W'($urandom_range(32767));
        end else if (kind <= 7) begin
          d[n*IN_W +: IN_W] = IN_W'(int'($urandom_range(128)) - 64);
        end else begin
          case ($urandom_range(2))
            0:       d[n*IN_W +: IN_W] = SAMPLE_MAX;
            1:       d[n*IN_W +: IN_W] = SAMPLE_MIN;
            default: d[n*IN_W +: IN_W] = '0;
          endcase
        end
      end
      send_vec(d);
    end
    in_tvalid <= 1'b0;

    // drain, then let the pipeline settle
    while (sb.pending_coefs.size() != 0) @(posedge clk);
    repeat (2 * NUM_STG) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
